/* hw/rtl/jdc_pkg.sv */
// ============================================================================
// jdc_pkg: shared constants, types and tables for the Julian day converter
// Holds the field widths, the scaled-integer constants of the date method,
// the reciprocal constants for the division stages, and the month tables.
// ============================================================================
package jdc_pkg;

	// Field widths of the input transaction.
	localparam int DAY_NUMBER_BITS = 23;
	localparam int FRACTION_BITS   = 32;

	// Number of register stages from input to output.
	localparam int PIPE_DEPTH = 10;

	// Output field widths.
	localparam int YEAR_W   = 16;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int SECOND_W = 22;

	// Gregorian century correction: cent = (4*Z - 7468865) / 146097.
	localparam int X1_W = DAY_NUMBER_BITS + 2;
	localparam logic [DAY_NUMBER_BITS-1:0] GREG_START = DAY_NUMBER_BITS'(2299161);
	localparam logic [X1_W-1:0] CENT_OFS = X1_W'(7468865);
	localparam logic [17:0] CENT_DIV = 18'd146097;
	localparam longint unsigned M1 = (64'd1 << X1_W) / 64'd146097;
	localparam int M1_W = $clog2(M1 + 1);

	// Year count: cyc = (20*shifted - 2442) / 7305.
	localparam int SHF_W = DAY_NUMBER_BITS + 1;
	localparam int X2_W  = SHF_W + 5;
	localparam logic [SHF_W-1:0] DATE_OFS = SHF_W'(1524);
	localparam logic [X2_W-1:0] YEAR_OFS = X2_W'(2442);
	localparam logic [12:0] YEAR_DIV = 13'd7305;
	localparam longint unsigned M2 = (64'd1 << X2_W) / 64'd7305;
	localparam int M2_W  = $clog2(M2 + 1);
	localparam int CYC_W = M2_W;
	localparam logic [10:0] YEAR_DAYS4 = 11'd1461;

	// Day within the shifted year and month code.
	localparam int REM_W   = 9;
	localparam int MCODE_W = 4;
	localparam logic [MCODE_W-1:0] MCODE_WRAP = MCODE_W'(14);
	localparam logic [YEAR_W-1:0] YEAR_OFS_LATE  = YEAR_W'(4716);
	localparam logic [YEAR_W-1:0] YEAR_OFS_EARLY = YEAR_W'(4715);

	// One enable bit per pipeline stage, index 1 is the first stage.
	typedef logic [PIPE_DEPTH:1] stage_en_t;

	// Time-of-day fields as they travel down the pipeline.
	typedef struct packed {
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [SECOND_W-1:0] second_fixed;
	} tod_t;

	// Month code: the largest m with 306001*m <= 10000*r. Each threshold
	// is compared on its own and the hits are counted.
	function automatic logic [MCODE_W-1:0] month_code(input logic [REM_W-1:0] r);
		logic [MCODE_W-1:0] n;
		n = '0;
		for (int m = 1; m < 16; m++) begin
			if (int'(r) * 10000 >= m * 306001) begin
				n = n + MCODE_W'(1);
			end
		end
		return n;
	endfunction

	// Days before the month with code m: floor(30.6001 * m), picked from a
	// table of constants.
	function automatic logic [REM_W-1:0] month_start(input logic [MCODE_W-1:0] m);
		logic [REM_W-1:0] v;
		v = '0;
		for (int k = 0; k < 16; k++) begin
			if (m == MCODE_W'(k)) begin
				v = REM_W'((k * 306001) / 10000);
			end
		end
		return v;
	endfunction

endpackage

/* hw/rtl/jdc_in_if.sv */
// ============================================================================
// jdc_in_if: input channel of the Julian day converter
// Carries one timestamp per transaction with a valid/ready handshake.
// ============================================================================
interface jdc_in_if;
	import jdc_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [DAY_NUMBER_BITS-1:0] day_number;
	logic [FRACTION_BITS-1:0]   day_fraction;

	modport source (output valid, day_number, day_fraction, input ready);
	modport sink   (input valid, day_number, day_fraction, output ready);
endinterface

/* hw/rtl/jdc_out_if.sv */
// ============================================================================
// jdc_out_if: output channel of the Julian day converter
// Carries one calendar date and time of day per transaction.
// ============================================================================
interface jdc_out_if;
	import jdc_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [YEAR_W-1:0]   year;
	logic [MONTH_W-1:0]         month;
	logic [DAY_W-1:0]           day;
	logic [HOUR_W-1:0]          hour;
	logic [MINUTE_W-1:0]        minute;
	logic [SECOND_W-1:0]        second_fixed;

	modport source (output valid, year, month, day, hour, minute, second_fixed,
		input ready);
	modport sink   (input valid, year, month, day, hour, minute, second_fixed,
		output ready);
endinterface

/* hw/rtl/jdc_date.sv */
// ============================================================================
// jdc_date: date datapath of the Julian day converter
// Ten-stage pipeline turning a day count into year, month and day. The century
// and year divisions use a reciprocal estimate, a back-multiply and one correction.
// ============================================================================
module jdc_date (
	input  logic                                clk,
	input  jdc_pkg::stage_en_t                  en,
	input  logic [jdc_pkg::DAY_NUMBER_BITS-1:0] day_number,
	output logic signed [jdc_pkg::YEAR_W-1:0]   year,
	output logic [jdc_pkg::MONTH_W-1:0]         month,
	output logic [jdc_pkg::DAY_W-1:0]           day
);
	import jdc_pkg::*;

	localparam int P1_W = X1_W + M1_W;
	localparam int P2_W = X2_W + M2_W;
	localparam int YD_W = CYC_W + 11;

	localparam logic [M1_W-1:0] M1_C = M1_W'(M1);
	localparam logic [M2_W-1:0] M2_C = M2_W'(M2);

	// Stage registers.
	logic [DAY_NUMBER_BITS-1:0] zday_s1, zday_s2, zday_s3;
	logic                       greg_s1, greg_s2, greg_s3;
	logic [X1_W-1:0]            x1_s1, x1_s2, qd1_s2;
	logic [P1_W-1:0]            p1_s1;
	logic [M1_W-1:0]            q1_s2, cent_s3;
	logic [SHF_W-1:0]           shf_s4, shf_s5, shf_s6, shf_s7;
	logic [X2_W-1:0]            x2_s4, x2_s5, x2_s6, qd2_s6;
	logic [P2_W-1:0]            p2_s5;
	logic [M2_W-1:0]            q2_s6;
	logic [CYC_W-1:0]           cyc_s7, cyc_s8, cyc_s9;
	logic [REM_W-1:0]           rem_s8, rem_s9;
	logic [MCODE_W-1:0]         mcode_s9;
	logic signed [YEAR_W-1:0]   year_s10;
	logic [MONTH_W-1:0]         month_s10;
	logic [DAY_W-1:0]           day_s10;

	// Combinational values between the stages.
	logic [X1_W-1:0]    x1_d;
	logic [X1_W-1:0]    r1_d;
	logic [M1_W-1:0]    cent_d;
	logic [SHF_W-1:0]   adj_d, shf_d;
	logic [X2_W-1:0]    x2_d;
	logic [X2_W-1:0]    r2_d;
	logic [CYC_W-1:0]   cyc_d;
	logic [YD_W-1:0]    yd_d;
	logic [REM_W-1:0]   rem_d;
	logic [MCODE_W-1:0] mon_d;

	// Stage 1: numerator of the century term and its reciprocal product.
	assign x1_d = {day_number, 2'b00} - CENT_OFS;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			zday_s1 <= day_number;
			greg_s1 <= (day_number >= GREG_START);
			x1_s1   <= x1_d;
			p1_s1   <= x1_d * M1_C;
		end
	end

	// Stage 2: quotient estimate and its back-multiply.
	always_ff @(posedge clk) begin
		if (en[2]) begin
			zday_s2 <= zday_s1;
			greg_s2 <= greg_s1;
			x1_s2   <= x1_s1;
			q1_s2   <= p1_s1[P1_W-1:X1_W];
			qd1_s2  <= X1_W'(p1_s1[P1_W-1:X1_W]) * X1_W'(CENT_DIV);
		end
	end

	// Stage 3: correct the estimate when the remainder reaches the divisor.
	assign r1_d   = x1_s2 - qd1_s2;
	assign cent_d = q1_s2 + M1_W'(r1_d >= X1_W'(CENT_DIV));

	always_ff @(posedge clk) begin
		if (en[3]) begin
			zday_s3 <= zday_s2;
			greg_s3 <= greg_s2;
			cent_s3 <= cent_d;
		end
	end

	// Stage 4: Gregorian adjustment, day offset and the year numerator.
	always_comb begin
		adj_d = SHF_W'(zday_s3);
		if (greg_s3) begin
			adj_d = SHF_W'(zday_s3) + SHF_W'(1) + SHF_W'(cent_s3) - SHF_W'(cent_s3 >> 2);
		end
	end

	assign shf_d = adj_d + DATE_OFS;
	assign x2_d  = X2_W'({shf_d, 4'b0000}) + X2_W'({shf_d, 2'b00}) - YEAR_OFS;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			shf_s4 <= shf_d;
			x2_s4  <= x2_d;
		end
	end

	// Stage 5: reciprocal product for the year count.
	always_ff @(posedge clk) begin
		if (en[5]) begin
			shf_s5 <= shf_s4;
			x2_s5  <= x2_s4;
			p2_s5  <= x2_s4 * M2_C;
		end
	end

	// Stage 6: year estimate and its back-multiply.
	always_ff @(posedge clk) begin
		if (en[6]) begin
			shf_s6 <= shf_s5;
			x2_s6  <= x2_s5;
			q2_s6  <= p2_s5[P2_W-1:X2_W];
			qd2_s6 <= X2_W'(p2_s5[P2_W-1:X2_W]) * X2_W'(YEAR_DIV);
		end
	end

	// Stage 7: corrected year count.
	assign r2_d  = x2_s6 - qd2_s6;
	assign cyc_d = CYC_W'(q2_s6) + CYC_W'(r2_d >= X2_W'(YEAR_DIV));

	always_ff @(posedge clk) begin
		if (en[7]) begin
			shf_s7 <= shf_s6;
			cyc_s7 <= cyc_d;
		end
	end

	// Stage 8: days into the shifted year.
	assign yd_d  = cyc_s7 * YEAR_DAYS4;
	assign rem_d = REM_W'(shf_s7 - SHF_W'(yd_d >> 2));

	always_ff @(posedge clk) begin
		if (en[8]) begin
			cyc_s8 <= cyc_s7;
			rem_s8 <= rem_d;
		end
	end

	// Stage 9: month code from the threshold table.
	always_ff @(posedge clk) begin
		if (en[9]) begin
			cyc_s9   <= cyc_s8;
			rem_s9   <= rem_s8;
			mcode_s9 <= month_code(rem_s8);
		end
	end

	// Stage 10: day of month, civil month and year.
	assign mon_d = (mcode_s9 < MCODE_WRAP) ? mcode_s9 - MCODE_W'(1) : mcode_s9 - MCODE_W'(13);

	always_ff @(posedge clk) begin
		if (en[10]) begin
			day_s10   <= DAY_W'(rem_s9 - month_start(mcode_s9));
			month_s10 <= MONTH_W'(mon_d);
			if (mon_d > MCODE_W'(2)) begin
				year_s10 <= YEAR_W'(cyc_s9) - YEAR_OFS_LATE;
			end else begin
				year_s10 <= YEAR_W'(cyc_s9) - YEAR_OFS_EARLY;
			end
		end
	end

	assign year  = year_s10;
	assign month = month_s10;
	assign day   = day_s10;

endmodule

/* hw/rtl/jdc_time.sv */
// ============================================================================
// jdc_time: time-of-day datapath of the Julian day converter
// Scales the day fraction to hours, minutes and seconds in two stages, then
// carries the result down a delay line that matches the date pipeline.
// ============================================================================
module jdc_time (
	input  logic                              clk,
	input  jdc_pkg::stage_en_t                en,
	input  logic [jdc_pkg::FRACTION_BITS-1:0] day_fraction,
	output jdc_pkg::tod_t                     tod
);
	import jdc_pkg::*;

	localparam int FB = FRACTION_BITS;

	logic [FB+4:0]  p24_d;
	logic [FB+10:0] p1440_d;
	logic [FB+16:0] p86400_d;

	logic [4:0]  hr_s1;
	logic [10:0] tmin_s1;
	logic [16:0] tsec_s1;
	logic [15:0] sub_s1;

	logic [MINUTE_W-1:0] mn_d;
	logic [5:0]          sec_d;

	tod_t tod_s [2:PIPE_DEPTH];

	// Stage 1: whole hours, minutes and seconds of the day.
	assign p24_d    = day_fraction * 5'd24;
	assign p1440_d  = day_fraction * 11'd1440;
	assign p86400_d = day_fraction * 17'd86400;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			hr_s1   <= p24_d[FB+4:FB];
			tmin_s1 <= p1440_d[FB+10:FB];
			tsec_s1 <= p86400_d[FB+16:FB];
			sub_s1  <= p86400_d[FB-1 -: 16];
		end
	end

	// Stage 2: minute of hour and second of minute.
	assign mn_d  = MINUTE_W'(tmin_s1 - 11'(hr_s1) * 11'd60);
	assign sec_d = 6'(tsec_s1 - 17'(tmin_s1) * 17'd60);

	// Stage 2 register and the delay line aligned with the date stages.
	always_ff @(posedge clk) begin
		if (en[2]) begin
			tod_s[2].hour         <= hr_s1;
			tod_s[2].minute       <= mn_d;
			tod_s[2].second_fixed <= {sec_d, sub_s1};
		end
		for (int k = 3; k <= PIPE_DEPTH; k++) begin
			if (en[k]) begin
				tod_s[k] <= tod_s[k-1];
			end
		end
	end

	assign tod = tod_s[PIPE_DEPTH];

endmodule

/* hw/rtl/julian_day_to_calendar.sv */
// ============================================================================
// julian_day_to_calendar: Julian day count to civil date and time
// Pipelined converter: date path, time path and per-stage flow control.
// ============================================================================
// Usage:
//   jd_in carries one timestamp per transaction: day_number is the Julian
//   date plus one half day (integer part) and day_fraction the binary
//   fraction of the day since midnight.
//   cal_out carries the astronomical year, month, day of month, hour,
//   minute and seconds with sixteen fractional bits, truncated.
//   Days from 2299161 on use the Gregorian calendar, earlier ones Julian.
//   cal_out.valid is the valid bit of the last of the ten register stages.
//   Throughput is one transaction per cycle while the receiver does not
//   stall; the date path holds the reciprocal multiply, back-multiply and
//   correction step of each division among its ten register stages.
//   Each stage has its own valid bit and advances whenever the stage after
//   it is empty or moving, so a stalled receiver holds the output and the
//   stages fill up behind it; empty stages are still filled while stalled.
//   Reset clears all valid bits; no transaction is in flight after it.
// ============================================================================
module julian_day_to_calendar (
	input  logic      clk,
	input  logic      arst_n,
	jdc_in_if.sink    jd_in,
	jdc_out_if.source cal_out
);
	import jdc_pkg::*;

	logic vld_s [1:PIPE_DEPTH];
	stage_en_t en;
	tod_t tod;

	// Stage enables: a stage loads when it is empty or its successor moves.
	always_comb begin
		en[PIPE_DEPTH] = !vld_s[PIPE_DEPTH] || cal_out.ready;
		for (int k = PIPE_DEPTH - 1; k >= 1; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign jd_in.ready = en[1];

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= PIPE_DEPTH; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			if (en[1]) begin
				vld_s[1] <= jd_in.valid;
			end
			for (int k = 2; k <= PIPE_DEPTH; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// Date path.
	jdc_date u_date (
		.clk        (clk),
		.en         (en),
		.day_number (jd_in.day_number),
		.year       (cal_out.year),
		.month      (cal_out.month),
		.day        (cal_out.day)
	);

	// Time path.
	jdc_time u_time (
		.clk          (clk),
		.en           (en),
		.day_fraction (jd_in.day_fraction),
		.tod          (tod)
	);

	assign cal_out.valid        = vld_s[PIPE_DEPTH];
	assign cal_out.hour         = tod.hour;
	assign cal_out.minute       = tod.minute;
	assign cal_out.second_fixed = tod.second_fixed;

endmodule

/* tb/tb_top.sv */
// ============================================================================
// tb_top: testbench for the Julian day to calendar converter
// Drives timestamps into jd_in and predicts the civil date and time of each
// one with integer arithmetic. Every cal_out transaction is compared field by
// field with the oldest prediction. The run covers the calendar switch, the
// extremes of both fields, and time-of-day boundaries, then random traffic
// under four phases of sender idling and receiver stalling.
// ============================================================================
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import jdc_pkg::*;

	// Cycles without any transaction before the run is declared hung.
	localparam int HANG_LIMIT = 2000;
	localparam int ITEMS_PER_PHASE = 300;

	// One predicted or observed converter result.
	typedef struct packed {
		logic signed [YEAR_W-1:0] year;
		logic [MONTH_W-1:0]       month;
		logic [DAY_W-1:0]         day;
		logic [HOUR_W-1:0]        hour;
		logic [MINUTE_W-1:0]      minute;
		logic [SECOND_W-1:0]      second_fixed;
	} civil_time_t;

	// Holds the predicted civil dates in arrival order and checks results.
	class cal_scoreboard;
		civil_time_t pending_dates[$];
		int          errors;

		function new();
			errors = 0;
		endfunction

		// Meeus conversion with the real constants as exact integer ratios.
		function civil_time_t civil_from_julian(logic [DAY_NUMBER_BITS-1:0] dn,
			logic [FRACTION_BITS-1:0] fr);
			longint unsigned z, adj, cent, shifted, cyc, yeardays, rem, mcode;
			longint unsigned dom, mon, yr, f, hr, tot_min, scaled, tot_sec;
			longint unsigned sec_rem, sub, secfix;
			civil_time_t     r;
			z = dn;
			adj = z;
			// The Gregorian century correction applies from the calendar switch on.
			if (z >= longint'(GREG_START)) begin
				cent = (4 * z - 7468865) / 146097;
				adj = z + 1 + cent - cent / 4;
			end
			shifted  = adj + 1524;
			cyc      = (20 * shifted - 2442) / 7305;
			yeardays = (1461 * cyc) / 4;
			rem      = shifted - yeardays;
			mcode    = (10000 * rem) / 306001;
			dom      = rem - (306001 * mcode) / 10000;
			mon      = (mcode < 14) ? mcode - 1 : mcode - 13;
			yr       = (mon > 2) ? cyc - 4716 : cyc - 4715;

			// Time of day, split from exact products without rounding.
			f       = fr;
			hr      = (f * 24) >> FRACTION_BITS;
			tot_min = (f * 1440) >> FRACTION_BITS;
			scaled  = f * 86400;
			tot_sec = scaled >> FRACTION_BITS;
			sec_rem = scaled & ((64'd1 << FRACTION_BITS) - 1);
			sub     = (sec_rem << 16) >> FRACTION_BITS;
			secfix  = ((tot_sec - tot_min * 60) << 16) + sub;

			r.year         = YEAR_W'(yr);
			r.month        = MONTH_W'(mon);
			r.day          = DAY_W'(dom);
			r.hour         = HOUR_W'(hr);
			r.minute       = MINUTE_W'(tot_min - 60 * hr);
			r.second_fixed = SECOND_W'(secfix);
			return r;
		endfunction

		// An accepted timestamp yields exactly one expected result.
		function void note_input(logic [DAY_NUMBER_BITS-1:0] dn,
			logic [FRACTION_BITS-1:0] fr);
			pending_dates.push_back(civil_from_julian(dn, fr));
		endfunction

		task report_mismatch(string what);
			$display("[%0t] MISMATCH %s", $realtime, what);
			errors++;
		endtask

		// Compare one accepted result with the oldest prediction.
		task check_result(civil_time_t got);
			civil_time_t exp_date;
			if (pending_dates.size() == 0) begin
				report_mismatch($sformatf("unexpected result %0d-%0d-%0d",
					got.year, got.month, got.day));
				return;
			end
			exp_date = pending_dates.pop_front();
			if (got.year !== exp_date.year)
				report_mismatch($sformatf("year got %0d exp %0d", got.year, exp_date.year));
			if (got.month !== exp_date.month)
				report_mismatch($sformatf("month got %0d exp %0d", got.month, exp_date.month));
			if (got.day !== exp_date.day)
				report_mismatch($sformatf("day got %0d exp %0d", got.day, exp_date.day));
			if (got.hour !== exp_date.hour)
				report_mismatch($sformatf("hour got %0d exp %0d", got.hour, exp_date.hour));
			if (got.minute !== exp_date.minute)
				report_mismatch($sformatf("minute got %0d exp %0d", got.minute,
					exp_date.minute));
			if (got.second_fixed !== exp_date.second_fixed)
				report_mismatch($sformatf("second_fixed got %h exp %h", got.second_fixed,
					exp_date.second_fixed));
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   tx_idle_pct;
	int   rx_stall_pct;
	int   hang_count;

	cal_scoreboard sb = new();

	jdc_in_if  jd_in();
	jdc_out_if cal_out();

	julian_day_to_calendar dut (
		.clk    (clk),
		.arst_n (arst_n),
		.jd_in  (jd_in),
		.cal_out(cal_out)
	);

	// Clock generation.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Receiver: ready changes on the falling edge, stalling at the phase rate.
	always @(negedge clk) begin
		cal_out.ready <= ($urandom_range(99) >= rx_stall_pct);
	end

	// Monitor: note accepted timestamps, check accepted results, watch for hangs.
	always @(posedge clk) begin
		civil_time_t got;
		if (jd_in.valid === 1'b1 && jd_in.ready === 1'b1) begin
			sb.note_input(jd_in.day_number, jd_in.day_fraction);
		end
		if (cal_out.valid === 1'b1 && cal_out.ready === 1'b1) begin
			got.year         = cal_out.year;
			got.month        = cal_out.month;
			got.day          = cal_out.day;
			got.hour         = cal_out.hour;
			got.minute       = cal_out.minute;
			got.second_fixed = cal_out.second_fixed;
			sb.check_result(got);
		end
		if ((jd_in.valid === 1'b1 && jd_in.ready === 1'b1) ||
			(cal_out.valid === 1'b1 && cal_out.ready === 1'b1)) begin
			hang_count = 0;
		end else begin
			hang_count++;
		end
		if (hang_count >= HANG_LIMIT) begin
			$display("[%0t] timeout: no transaction for %0d cycles", $realtime, hang_count);
			$display("julian_day_to_calendar verification failed");
			$finish;
		end
	end

	// Send one timestamp, with random idle cycles ahead of it, and hold it
	// until the converter accepts it.
	task send_timestamp(logic [DAY_NUMBER_BITS-1:0] dn, logic [FRACTION_BITS-1:0] fr);
		while ($urandom_range(99) < tx_idle_pct) begin
			jd_in.valid <= 1'b0;
			@(negedge clk);
		end
		jd_in.valid        <= 1'b1;
		jd_in.day_number   <= dn;
		jd_in.day_fraction <= fr;
		do @(posedge clk); while (jd_in.ready !== 1'b1);
		@(negedge clk);
	endtask

	// Random day number: full range, around the calendar switch, modern era, or the earliest days.
	function logic [DAY_NUMBER_BITS-1:0] random_day();
		case ($urandom_range(3))
			0: return DAY_NUMBER_BITS'($urandom);
			1: return DAY_NUMBER_BITS'(2299161 - 1500 + $urandom_range(3000));
			2: return DAY_NUMBER_BITS'($urandom_range(2400000, 2500000));
			default: return DAY_NUMBER_BITS'($urandom_range(0, 3000));
		endcase
	endfunction

	// Random fraction: mostly uniform, some near hour, minute or second
	// boundaries, a few at the extremes.
	function logic [FRACTION_BITS-1:0] random_fraction();
		longint unsigned div, k, base;
		case ($urandom_range(5))
			0, 1, 2: return FRACTION_BITS'($urandom);
			3, 4: begin
				case ($urandom_range(2))
					0: div = 24;
					1: div = 1440;
					default: div = 86400;
				endcase
				k = $urandom_range(1, int'(div) - 1);
				base = ((k << FRACTION_BITS) + div - 1) / div;
				return FRACTION_BITS'(base + $urandom_range(4) - 2);
			end
			default: return $urandom_range(1) ? '1 : '0;
		endcase
	endfunction

	// Stimulus: directed timestamps, then random traffic in four flow phases.
	initial begin
		arst_n             = 1'b0;
		jd_in.valid        = 1'b0;
		jd_in.day_number   = '0;
		jd_in.day_fraction = '0;
		cal_out.ready      = 1'b0;
		tx_idle_pct        = 0;
		rx_stall_pct       = 0;
		hang_count         = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: field extremes, the calendar switch, leap days, and
		// time-of-day boundaries.
		send_timestamp('0, '0);
		send_timestamp('0, '1);
		send_timestamp('1, '0);
		send_timestamp('1, '1);
		send_timestamp(DAY_NUMBER_BITS'(8388606), 32'h8000_0000);
		send_timestamp(DAY_NUMBER_BITS'(1), 32'h7FFF_FFFF);
		send_timestamp(DAY_NUMBER_BITS'(59), 32'd178956970);
		send_timestamp(DAY_NUMBER_BITS'(60), 32'd178956971);
		send_timestamp(DAY_NUMBER_BITS'(2299160), 32'd2982616);
		send_timestamp(DAY_NUMBER_BITS'(2299161), 32'd2982617);
		send_timestamp(DAY_NUMBER_BITS'(2299162), 32'd49711);
		send_timestamp(DAY_NUMBER_BITS'(2305447), 32'd49710);
		send_timestamp(DAY_NUMBER_BITS'(2415079), 32'hAAAA_AAAA);
		send_timestamp(DAY_NUMBER_BITS'(2415080), 32'h5555_5555);
		send_timestamp(DAY_NUMBER_BITS'(2451545), 32'hC000_0000);
		send_timestamp(DAY_NUMBER_BITS'(2451604), 32'h4000_0000);
		send_timestamp(DAY_NUMBER_BITS'(2451605), 32'hFFFF_0000);
		send_timestamp(DAY_NUMBER_BITS'(2488069), 32'h0000_FFFF);
		send_timestamp(DAY_NUMBER_BITS'(1721423), 32'd4294967118);
		send_timestamp(DAY_NUMBER_BITS'(1721424), 32'd4294788339);

		// Random phases: no idling, sender idle, receiver stall, both.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 85; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 85; end
				default: begin tx_idle_pct = 34; rx_stall_pct = 34; end
			endcase
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				send_timestamp(random_day(), random_fraction());
			end
		end
		jd_in.valid <= 1'b0;

		// Drain: wait for every predicted result, then watch for stray ones.
		while (sb.pending_dates.size() != 0) @(posedge clk);
		repeat (4 * PIPE_DEPTH) @(posedge clk);

		if (sb.errors == 0 && sb.pending_dates.size() == 0) begin
			$display("julian_day_to_calendar verification clean");
		end else begin
			$display("julian_day_to_calendar verification failed");
		end
		$finish;
	end

endmodule

/* julian_day_to_calendar.f */
hw/rtl/jdc_pkg.sv
hw/rtl/jdc_in_if.sv
hw/rtl/jdc_out_if.sv
hw/rtl/jdc_date.sv
hw/rtl/jdc_time.sv
hw/rtl/julian_day_to_calendar.sv
tb/tb_top.sv
